/* design/ffa_pkg.sv */
// ffa_pkg: arena geometry, header entry layout, memory request type and opcodes
// shared by the first-fit allocator interfaces, controller and top level
// no dependencies
package ffa_pkg;

  localparam int unsigned ARENA_BYTES  = 1024;
  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned MAX_VISITS   = 78;

  localparam int unsigned LEN_W  = 10;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned OFF_W  = $clog2(ARENA_BYTES);
  localparam int unsigned PTR_W  = OFF_W + 1;
  localparam int unsigned SIZE_W = OFF_W;
  localparam int unsigned VIS_W  = $clog2(MAX_VISITS + 1);
  localparam int unsigned SUM_W  = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 2;

  localparam logic [PTR_W-1:0]  END_OF_LIST = PTR_W'(ARENA_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE   = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [OFF_W-1:0]  HDR_OFF     = OFF_W'(HEADER_BYTES % ARENA_BYTES);

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_FREE   = 1'b1;
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_NO_FIT = 1'b1;

  typedef struct packed {
    logic [PTR_W-1:0]  next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic             we;
    logic [OFF_W-1:0] waddr;
    hdr_t             wdata;
    logic             re;
    logic [OFF_W-1:0] raddr;
  } mem_req_t;

  // header offset of a released payload, wrapping within the arena
  function automatic logic [OFF_W-1:0] free_hdr(logic [ADDR_W-1:0] addr);
    logic [OFF_W-1:0] a;
    a = OFF_W'(addr);
    return a - HDR_OFF;
  endfunction

endpackage

/* design/ffa_req_if.sv */
// ffa_req_if: request channel of the allocator, valid/ready with opcode and operands
// depends on ffa_pkg
interface ffa_req_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [LEN_W-1:0]  request_length;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, opcode, request_length, block_address, input ready);
  modport sink   (input valid, opcode, request_length, block_address, output ready);
endinterface

/* design/ffa_rsp_if.sv */
// ffa_rsp_if: response channel of the allocator, valid/ready with status and payload offset
// depends on ffa_pkg
interface ffa_rsp_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ADDR_W-1:0] payload_address;

  modport source (output valid, status, payload_address, input ready);
  modport sink   (input valid, status, payload_address, output ready);
endinterface

/* design/ffa_hdr_ram.sv */
// ffa_hdr_ram: generic single-write, single-read synchronous RAM, registered read data
// no dependencies
module ffa_hdr_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 21,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ffa_ctrl.sv */
// ffa_ctrl: clearing pass, free-list walk, split and push sequencer with output register
// depends on ffa_pkg, ffa_req_if, ffa_rsp_if; drives the header RAM through mem_req_t
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ffa_req_if.sink  req_i,
  ffa_rsp_if.source rsp_o,
  output mem_req_t mem_o,
  input  hdr_t     rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_PREV  = 3'd4;
  localparam logic [2:0] S_CUR   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [OFF_W-1:0]  clr_q, clr_d;
  logic [PTR_W-1:0]  free_head_q, free_head_d;
  logic [OFF_W-1:0]  cur_q, cur_d;
  logic [OFF_W-1:0]  prev_q, prev_d;
  logic [SIZE_W-1:0] prev_size_q, prev_size_d;
  logic              have_prev_q, have_prev_d;
  logic [VIS_W-1:0]  visits_q, visits_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [OFF_W-1:0]  rest_q, rest_d;
  logic [SIZE_W-1:0] rest_size_q, rest_size_d;
  logic              res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_status_q, out_status_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;

  logic [SUM_W-1:0]  need, avail_ext, rest_sum;
  logic              fit, more;
  logic [VIS_W-1:0]  vis_nx;
  logic              in_xfer;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;

  assign need      = SUM_W'(len_q) + SUM_W'(HEADER_BYTES);
  assign avail_ext = SUM_W'(rdata_i.size);
  assign rest_sum  = SUM_W'(cur_q) + need;
  assign fit       = (avail_ext >= need) && (rest_sum < SUM_W'(ARENA_BYTES));
  assign vis_nx    = visits_q + VIS_W'(1);
  assign more      = (rdata_i.next < END_OF_LIST) && (vis_nx < VIS_W'(MAX_VISITS));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_head_d  = free_head_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_size_d  = prev_size_q;
    have_prev_d  = have_prev_q;
    visits_d     = visits_q;
    len_d        = len_q;
    rest_d       = rest_q;
    rest_size_d  = rest_size_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    mem_o        = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        if (clr_q == '0) begin
          mem_o.wdata.size = INIT_SIZE;
          mem_o.wdata.next = END_OF_LIST;
        end
        clr_d = clr_q + OFF_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          len_d = req_i.request_length;
          if (req_i.opcode == OP_FREE) begin
            cur_d       = free_hdr(req_i.block_address);
            mem_o.re    = 1'b1;
            mem_o.raddr = free_hdr(req_i.block_address);
            state_d     = S_FREE;
          end else if (free_head_q >= END_OF_LIST) begin
            res_status_d = ST_NO_FIT;
            res_addr_d   = '0;
            state_d      = S_OUT;
          end else begin
            cur_d       = free_head_q[OFF_W-1:0];
            mem_o.re    = 1'b1;
            mem_o.raddr = free_head_q[OFF_W-1:0];
            visits_d    = '0;
            have_prev_d = 1'b0;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (fit) begin
          rest_d           = rest_sum[OFF_W-1:0];
          rest_size_d      = SIZE_W'(avail_ext - need);
          mem_o.we         = 1'b1;
          mem_o.waddr      = rest_sum[OFF_W-1:0];
          mem_o.wdata.size = SIZE_W'(avail_ext - need);
          mem_o.wdata.next = rdata_i.next;
          state_d          = have_prev_q ? S_PREV : S_CUR;
        end else begin
          prev_d      = cur_q;
          prev_size_d = rdata_i.size;
          have_prev_d = 1'b1;
          visits_d    = vis_nx;
          cur_d       = rdata_i.next[OFF_W-1:0];
          if (more) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = rdata_i.next[OFF_W-1:0];
          end else begin
            res_status_d = ST_NO_FIT;
            res_addr_d   = '0;
            state_d      = S_OUT;
          end
        end
      end
      S_PREV: begin
        // the remainder may have landed on the predecessor's own header
        mem_o.we         = 1'b1;
        mem_o.waddr      = prev_q;
        mem_o.wdata.size = (prev_q == rest_q) ? rest_size_q : prev_size_q;
        mem_o.wdata.next = PTR_W'(rest_q);
        state_d          = S_CUR;
      end
      S_CUR: begin
        mem_o.we         = 1'b1;
        mem_o.waddr      = cur_q;
        mem_o.wdata.size = SIZE_W'(len_q);
        mem_o.wdata.next = END_OF_LIST;
        if (!have_prev_q) begin
          free_head_d = PTR_W'(rest_q);
        end
        res_status_d = ST_DONE;
        res_addr_d   = ADDR_W'(SUM_W'(cur_q) + SUM_W'(HEADER_BYTES));
        state_d      = S_OUT;
      end
      S_FREE: begin
        mem_o.we         = 1'b1;
        mem_o.waddr      = cur_q;
        mem_o.wdata.size = rdata_i.size;
        mem_o.wdata.next = free_head_q;
        free_head_d      = PTR_W'(cur_q);
        res_status_d     = ST_DONE;
        res_addr_d       = '0;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_head_q <= '0;
      have_prev_q <= 1'b0;
      visits_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      have_prev_q <= have_prev_d;
      visits_q    <= visits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_size_q  <= prev_size_d;
    len_q        <= len_d;
    rest_q       <= rest_d;
    rest_size_q  <= rest_size_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.payload_address = out_addr_q;

  a_visits_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> visits_q < VIS_W'(MAX_VISITS))
    else $error("walk exceeded visit cap");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_fit_then_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && fit) |=> (state_q == S_PREV || state_q == S_CUR))
    else $error("split not followed by relink");

  a_prev_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PREV |-> have_prev_q)
    else $error("predecessor relink without predecessor");

  a_head_in_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q < END_OF_LIST)
    else $error("free list head outside arena");

endmodule

/* design/first_fit_free_list_allocator.sv */
// first-fit free-list allocator, one request and one response transfer at a time
// alloc: the walk reads one header RAM entry a cycle, giving up at the list end or the visit cap;
// on a fit it writes the remainder header, relinks any predecessor and writes the block header
// free: write the header back linked to the head; every request then loads the output register
// next request taken the cycle after the response register loads, even while it waits
// after reset a clearing pass rebuilds the header RAM; no request is taken meanwhile
module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  mem_req_t mem_req;
  hdr_t     rdata;

  ffa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .mem_o   (mem_req),
    .rdata_i (rdata)
  );

  ffa_hdr_ram #(
    .DEPTH (ARENA_BYTES),
    .WIDTH ($bits(hdr_t))
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule

/* bench/first_fit_free_list_allocator_test.sv */
// first_fit_free_list_allocator_test: drives alloc and free requests into the allocator and checks
// every response against an in-bench first-fit free-list predictor of the header arena
// depends on ffa_pkg, ffa_req_if, ffa_rsp_if and first_fit_free_list_allocator
module first_fit_free_list_allocator_test;
  import ffa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned RANDOM_ITEMS = 1735;

  typedef struct packed {
    logic              opcode;
    logic [LEN_W-1:0]  request_length;
    logic [ADDR_W-1:0] block_address;
  } alloc_request_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] payload_address;
  } alloc_reply_t;

  logic clk_i;
  logic rst_ni;

  ffa_req_if req_ch ();
  ffa_rsp_if rsp_ch ();

  first_fit_free_list_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // predicted arena: one header per byte offset
  logic [PTR_W-1:0]  list_head;
  logic [SIZE_W-1:0] hdr_len  [ARENA_BYTES];
  logic [PTR_W-1:0]  hdr_link [ARENA_BYTES];

  alloc_request_t    request_queue[$];
  alloc_reply_t      awaited_replies[$];
  logic [ADDR_W-1:0] live_payloads[$];
  logic [ADDR_W-1:0] last_released;

  bit           req_fired;
  bit           no_gaps;
  int           mismatches;
  int unsigned  stalled_cycles;
  alloc_reply_t due;

  always #5ns clk_i = ~clk_i;

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 20);
  endfunction

  // first-fit walk, split of the chosen block, remainder takes its place in the list
  function automatic alloc_reply_t place_block(int unsigned len);
    int unsigned  cur;
    int unsigned  prev;
    int unsigned  visits;
    int unsigned  rest_at;
    bit           have_prev;
    alloc_reply_t r;
    cur       = list_head;
    prev      = 0;
    visits    = 0;
    have_prev = 1'b0;
    r.status          = ST_NO_FIT;
    r.payload_address = '0;
    while (cur < ARENA_BYTES && visits < MAX_VISITS) begin
      rest_at = cur + HEADER_BYTES + len;
      visits++;
      if (int'(hdr_len[cur]) >= len + HEADER_BYTES && rest_at < ARENA_BYTES) begin
        hdr_len[rest_at]  = SIZE_W'(int'(hdr_len[cur]) - len - HEADER_BYTES);
        hdr_link[rest_at] = hdr_link[cur];
        if (have_prev) begin
          hdr_link[prev] = PTR_W'(rest_at);
        end else begin
          list_head = PTR_W'(rest_at);
        end
        hdr_len[cur]  = SIZE_W'(len);
        hdr_link[cur] = END_OF_LIST;
        r.status          = ST_DONE;
        r.payload_address = ADDR_W'(cur + HEADER_BYTES);
        live_payloads.push_back(r.payload_address);
        return r;
      end
      prev      = cur;
      have_prev = 1'b1;
      cur       = hdr_link[cur];
    end
    return r;
  endfunction

  // push onto the list head, header offset wraps below zero
  function automatic alloc_reply_t release_block(logic [ADDR_W-1:0] addr);
    logic [OFF_W-1:0] at;
    alloc_reply_t     r;
    at = OFF_W'(addr) - HDR_OFF;
    hdr_link[at] = list_head;
    list_head    = {1'b0, at};
    r.status          = ST_DONE;
    r.payload_address = '0;
    return r;
  endfunction

  task automatic queue_request(logic op, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] addr);
    alloc_request_t item;
    item.opcode         = op;
    item.request_length = len;
    item.block_address  = addr;
    while (request_queue.size() >= 2) @(posedge clk_i);
    request_queue.push_back(item);
  endtask

  task automatic wait_idle();
    while (request_queue.size() > 0 || awaited_replies.size() > 0) @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_fired) begin
        if (request_queue.size() > 0 && !take_gap()) begin
          req_ch.valid          <= 1'b1;
          req_ch.opcode         <= request_queue[0].opcode;
          req_ch.request_length <= request_queue[0].request_length;
          req_ch.block_address  <= request_queue[0].block_address;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= !take_gap();
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    req_fired = 1'b0;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      req_fired = 1'b1;
      void'(request_queue.pop_front());
      if (req_ch.opcode == OP_ALLOC) begin
        awaited_replies.push_back(place_block(req_ch.request_length));
      end else begin
        awaited_replies.push_back(release_block(req_ch.block_address));
      end
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected response transfer: status %0d payload_address %0d",
               rsp_ch.status, rsp_ch.payload_address);
        mismatches++;
      end else begin
        due = awaited_replies.pop_front();
        if (rsp_ch.status !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.payload_address !== due.payload_address) begin
          $error("payload_address: expected %0d, actual %0d",
                 due.payload_address, rsp_ch.payload_address);
          mismatches++;
        end
      end
    end
    if (req_fired || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("first_fit_free_list_allocator_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      idx;
    logic [LEN_W-1:0] len;
    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_ALLOC;
    req_ch.request_length = '0;
    req_ch.block_address  = '0;
    rsp_ch.ready          = 1'b0;
    mismatches            = 0;
    stalled_cycles        = 0;
    no_gaps               = 1'b0;
    last_released         = ADDR_W'(HEADER_BYTES);
    for (int i = 0; i < ARENA_BYTES; i++) begin
      hdr_len[i]  = '0;
      hdr_link[i] = '0;
    end
    hdr_len[0]  = INIT_SIZE;
    hdr_link[0] = END_OF_LIST;
    list_head   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: oversize and exact fit, split to a zero remainder, wrap, cycles, stale headers
    queue_request(OP_ALLOC, 10'd1023, 10'd0);
    queue_request(OP_ALLOC, LEN_W'(ARENA_BYTES - HEADER_BYTES), 10'd1023);
    queue_request(OP_ALLOC, LEN_W'(ARENA_BYTES - 2 * HEADER_BYTES), 10'd0);
    queue_request(OP_ALLOC, 10'd0, 10'd1023);
    queue_request(OP_FREE, 10'd1023, ADDR_W'(HEADER_BYTES));
    queue_request(OP_ALLOC, LEN_W'(ARENA_BYTES - 3 * HEADER_BYTES), 10'd0);
    queue_request(OP_FREE, 10'd0, 10'd0);
    queue_request(OP_FREE, 10'd1023, ADDR_W'(HEADER_BYTES));
    queue_request(OP_ALLOC, 10'd1023, 10'd0);
    queue_request(OP_ALLOC, 10'd0, 10'd1023);
    queue_request(OP_FREE, 10'd0, 10'd1023);
    queue_request(OP_ALLOC, 10'd500, 10'd1023);
    queue_request(OP_FREE, 10'd1023, ADDR_W'(2 * HEADER_BYTES));
    queue_request(OP_FREE, 10'd0, ADDR_W'(2 * HEADER_BYTES));
    queue_request(OP_ALLOC, 10'd1000, 10'd0);
    queue_request(OP_ALLOC, 10'd20, 10'd682);
    queue_request(OP_ALLOC, 10'd341, 10'd341);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n >= 700 && n < 1000);
      if (n == 400 || n == 1300) begin
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 50 || live_payloads.size() == 0) begin
        idx = $urandom_range(0, 99);
        if (idx < 60) begin
          len = LEN_W'($urandom_range(0, 24));
        end else if (idx < 85) begin
          len = LEN_W'($urandom_range(25, 120));
        end else if (idx < 95) begin
          len = LEN_W'($urandom_range(121, 400));
        end else begin
          len = LEN_W'($urandom_range(0, 1023));
        end
        queue_request(OP_ALLOC, len, ADDR_W'($urandom_range(0, 1023)));
      end else if (pick < 92) begin
        idx = $urandom_range(0, live_payloads.size() - 1);
        last_released = live_payloads[idx];
        live_payloads.delete(idx);
        queue_request(OP_FREE, LEN_W'($urandom_range(0, 1023)), last_released);
      end else if (pick < 97) begin
        queue_request(OP_FREE, LEN_W'($urandom_range(0, 1023)),
                      ADDR_W'($urandom_range(0, 1023)));
      end else begin
        // double release
        queue_request(OP_FREE, LEN_W'($urandom_range(0, 1023)), last_released);
      end
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("first_fit_free_list_allocator_test passed");
    end else begin
      $display("first_fit_free_list_allocator_test failed");
    end
    $finish;
  end

endmodule

/* first_fit_free_list_allocator.f */
design/ffa_pkg.sv
design/ffa_req_if.sv
design/ffa_rsp_if.sv
design/ffa_hdr_ram.sv
design/ffa_ctrl.sv
design/first_fit_free_list_allocator.sv
bench/first_fit_free_list_allocator_test.sv
